// ===== rtl/sfs_pkg.sv =====
// shared types, widths and codes for the sprite frame sequencer
`default_nettype none

package sfs_pkg;

  // default sizing
  localparam int MaxFramesDef   = 256;
  localparam int MaxSheetDimDef = 4096;

  // field and internal widths
  localparam int ACT_W   = 3;
  localparam int TIME_W  = 32;
  localparam int TGT_W   = 8;
  localparam int FC_W    = 9;
  localparam int PER_W   = 31;
  localparam int DIM_W   = 13;
  localparam int FRM_W   = 10;
  localparam int POS_W   = 12;
  localparam int MODE_W  = 2;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 32;

  // reset value of the period register
  localparam logic [PER_W-1:0] PERIOD_RST = PER_W'(2000);

  // action codes
  localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PLAY    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PAUSE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STOP    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_GOTO    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RESTART = 3'd5;

  // run modes
  localparam logic [MODE_W-1:0] MODE_PLAY    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_STOP    = 2'd3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_FRAME_COUNT  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_PERIOD       = 3'd1;
  localparam logic [CIDX_W-1:0] REG_LOOP_ENABLE  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_COLUMNS      = 3'd3;
  localparam logic [CIDX_W-1:0] REG_ROWS         = 3'd4;
  localparam logic [CIDX_W-1:0] REG_SHEET_WIDTH  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_SHEET_HEIGHT = 3'd6;

  // input item
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] now_time;
    logic              direction;
    logic [TGT_W-1:0]  target_frame;
    logic              image_valid;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [TGT_W-1:0]  frame_index;
    logic [POS_W-1:0]  cell_left;
    logic [POS_W-1:0]  cell_top;
    logic [DIM_W-1:0]  cell_width;
    logic [DIM_W-1:0]  cell_height;
    logic [MODE_W-1:0] run_mode;
    logic              stop_event;
    logic              image_loaded;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/sprite_frame_sequencer_unit.sv =====
// sprite sheet animation sequencer with a shared divider and multiplier
`default_nettype none

// channel  | signals                              | direction
// ---------+--------------------------------------+----------
// in       | in_valid_i, in_stall_o, in_item_i    | item in
// out      | out_valid_o, out_stall_i, out_item_o | item out
// cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | register write
//
// from accepting an item to loading its result: 3 x 13 divider steps
// (cell width, cell height, frame row/column), the left and top multiplies, 1 load;
// the input stalls until then, so a new item is taken only once the last result is loaded.
// reset puts the registers at their documented values and the sequencer idle.
// a stalled result holds in the output register while the next item runs;
// that item waits before its result load until the register is free.

module sprite_frame_sequencer_unit
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES    = MaxFramesDef,
  parameter int MAX_SHEET_DIM = MaxSheetDimDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire in_item_t            in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      out_item_t           out_item_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CIDX_W-1:0]   cfg_index_i,
  input  wire logic [CDATA_W-1:0]  cfg_data_i
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVW = 3'd1;
  localparam logic [2:0] ST_DIVH = 3'd2;
  localparam logic [2:0] ST_DIVF = 3'd3;
  localparam logic [2:0] ST_MULL = 3'd4;
  localparam logic [2:0] ST_MULT = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam int CNT_W = $clog2(DIM_W);
  localparam int EXT_W = FRM_W + 1;
  localparam int PRD_W = FC_W + DIM_W;

  // configuration registers
  logic [FC_W-1:0]  frame_count_q;
  logic [PER_W-1:0] period_q;
  logic             loop_en_q;
  logic [FC_W-1:0]  columns_q;
  logic [FC_W-1:0]  rows_q;
  logic [DIM_W-1:0] sheet_w_q;
  logic [DIM_W-1:0] sheet_h_q;

  // sequencer state
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [FRM_W-1:0]  cur_q, cur_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic              img_q, img_d;
  logic              ev_q, ev_d;

  // control and datapath registers
  logic [2:0]       st_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIM_W-1:0] acc_q;
  logic [FC_W-1:0]  rem_q;
  logic [FC_W-1:0]  fidx_q, fidx_d;
  logic [DIM_W-1:0] cw_q, ch_q;
  logic [FC_W-1:0]  quo_q;
  logic [FC_W-1:0]  mod_q;
  logic [POS_W-1:0] left_q, top_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic in_acc;
  logic out_free;

  assign in_stall_o  = (st_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // effective frame count, columns, rows and sheet dimensions
  logic [FC_W-1:0]  fc;
  logic [FC_W-1:0]  cols;
  logic [FC_W-1:0]  rws;
  logic [DIM_W-1:0] sw_sat, sh_sat;

  always_comb begin
    fc = (frame_count_q == '0) ? FC_W'(1) : frame_count_q;
    if (32'(fc) > 32'(MAX_FRAMES)) begin
      fc = FC_W'(MAX_FRAMES);
    end
    cols   = (columns_q == '0) ? FC_W'(1) : columns_q;
    rws    = (rows_q == '0) ? FC_W'(1) : rows_q;
    sw_sat = (32'(sheet_w_q) > 32'(MAX_SHEET_DIM)) ? DIM_W'(MAX_SHEET_DIM) : sheet_w_q;
    sh_sat = (32'(sheet_h_q) > 32'(MAX_SHEET_DIM)) ? DIM_W'(MAX_SHEET_DIM) : sheet_h_q;
  end

  // command decode and frame stepping
  logic [TIME_W-1:0]       dt;
  logic                    tick_due;
  logic signed [EXT_W-1:0] fc_ext, fcm1, cur_ext, nxt, cd;

  always_comb begin
    dt       = in_item_i.now_time - last_q;
    tick_due = $signed(dt) > $signed({1'b0, period_q});
    fc_ext   = $signed({2'b00, fc});
    fcm1     = fc_ext - EXT_W'(1);
    cur_ext  = $signed({cur_q[FRM_W-1], cur_q});
    nxt      = cur_ext;
    mode_d   = mode_q;
    cur_d    = cur_q;
    last_d   = last_q;
    img_d    = img_q;
    ev_d     = 1'b0;
    case (in_item_i.action)
      ACT_TICK: begin
        if (img_q && (mode_q == MODE_PLAY || mode_q == MODE_REVERSE) && tick_due) begin
          last_d = in_item_i.now_time;
          if (mode_q == MODE_PLAY) begin
            nxt = cur_ext + EXT_W'(1);
            if (nxt >= fc_ext) begin
              if (loop_en_q) begin
                nxt = '0;
              end else begin
                nxt    = fcm1;
                mode_d = MODE_STOP;
                ev_d   = 1'b1;
              end
            end
          end else begin
            nxt = cur_ext - EXT_W'(1);
            if (nxt < 0) begin
              if (loop_en_q) begin
                nxt = fcm1;
              end else begin
                nxt    = '0;
                mode_d = MODE_STOP;
                ev_d   = 1'b1;
              end
            end
          end
          cur_d = nxt[FRM_W-1:0];
        end
      end
      ACT_PLAY: begin
        mode_d = in_item_i.direction ? MODE_PLAY : MODE_REVERSE;
      end
      ACT_PAUSE: begin
        mode_d = MODE_PAUSE;
      end
      ACT_STOP: begin
        mode_d = MODE_STOP;
        cur_d  = '0;
      end
      ACT_GOTO: begin
        if ({1'b0, in_item_i.target_frame} < fc) begin
          mode_d = MODE_PAUSE;
          cur_d  = FRM_W'(in_item_i.target_frame);
        end
      end
      ACT_RESTART: begin
        mode_d = in_item_i.direction ? MODE_PLAY : MODE_REVERSE;
        cur_d  = in_item_i.direction ? '1 : FRM_W'(fc);
        img_d  = in_item_i.image_valid;
      end
      default: begin
      end
    endcase
    // clamp the displayed frame into range
    cd = $signed({cur_d[FRM_W-1], cur_d});
    if (cd < 0) begin
      cd = '0;
    end else if (cd > fcm1) begin
      cd = fcm1;
    end
    fidx_d = cd[FC_W-1:0];
  end

  // shared restoring divider, one quotient bit per cycle
  logic [FC_W-1:0]  dvs;
  logic [FC_W:0]    trial;
  logic             qbit;
  logic [FC_W-1:0]  rem_nxt;
  logic [DIM_W-1:0] acc_nxt;
  logic             div_last;

  always_comb begin
    dvs      = (st_q == ST_DIVH) ? rws : cols;
    trial    = {rem_q, acc_q[DIM_W-1]};
    qbit     = trial >= {1'b0, dvs};
    rem_nxt  = qbit ? FC_W'(trial - {1'b0, dvs}) : trial[FC_W-1:0];
    acc_nxt  = {acc_q[DIM_W-2:0], qbit};
    div_last = (cnt_q == CNT_W'(DIM_W - 1));
  end

  // shared multiplier with saturation to the pixel range
  logic [FC_W-1:0]  mul_a;
  logic [DIM_W-1:0] mul_b;
  logic [PRD_W-1:0] prod;
  logic [POS_W-1:0] prod_sat;

  always_comb begin
    mul_a    = (st_q == ST_MULL) ? mod_q : quo_q;
    mul_b    = (st_q == ST_MULL) ? cw_q : ch_q;
    prod     = PRD_W'(mul_a) * PRD_W'(mul_b);
    prod_sat = (prod > PRD_W'({POS_W{1'b1}})) ? '1 : prod[POS_W-1:0];
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FC_W'(1);
      period_q      <= PERIOD_RST;
      loop_en_q     <= 1'b0;
      columns_q     <= FC_W'(1);
      rows_q        <= FC_W'(1);
      sheet_w_q     <= DIM_W'(1);
      sheet_h_q     <= DIM_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FRAME_COUNT:  frame_count_q <= cfg_data_i[FC_W-1:0];
        REG_PERIOD:       period_q      <= cfg_data_i[PER_W-1:0];
        REG_LOOP_ENABLE:  loop_en_q     <= cfg_data_i[0];
        REG_COLUMNS:      columns_q     <= cfg_data_i[FC_W-1:0];
        REG_ROWS:         rows_q        <= cfg_data_i[FC_W-1:0];
        REG_SHEET_WIDTH:  sheet_w_q     <= cfg_data_i[DIM_W-1:0];
        REG_SHEET_HEIGHT: sheet_h_q     <= cfg_data_i[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // animation state, updated once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAY;
      cur_q  <= '0;
      last_q <= '0;
      img_q  <= 1'b0;
      ev_q   <= 1'b0;
    end else if (in_acc) begin
      mode_q <= mode_d;
      cur_q  <= cur_d;
      last_q <= last_d;
      img_q  <= img_d;
      ev_q   <= ev_d;
    end
  end

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_acc) begin
            st_q <= ST_DIVW;
          end
        end
        ST_DIVW, ST_DIVH, ST_DIVF: begin
          cnt_q <= div_last ? '0 : cnt_q + CNT_W'(1);
          if (div_last) begin
            st_q <= (st_q == ST_DIVW) ? ST_DIVH : (st_q == ST_DIVH) ? ST_DIVF : ST_MULL;
          end
        end
        ST_MULL: begin
          st_q <= ST_MULT;
        end
        ST_MULT: begin
          st_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            st_q <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  // divider, multiplier and result datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          fidx_q <= fidx_d;
          acc_q  <= sw_sat;
          rem_q  <= '0;
        end
      end
      ST_DIVW: begin
        if (div_last) begin
          cw_q  <= acc_nxt;
          acc_q <= sh_sat;
          rem_q <= '0;
        end else begin
          acc_q <= acc_nxt;
          rem_q <= rem_nxt;
        end
      end
      ST_DIVH: begin
        if (div_last) begin
          ch_q  <= acc_nxt;
          acc_q <= DIM_W'(fidx_q);
          rem_q <= '0;
        end else begin
          acc_q <= acc_nxt;
          rem_q <= rem_nxt;
        end
      end
      ST_DIVF: begin
        acc_q <= acc_nxt;
        rem_q <= rem_nxt;
        if (div_last) begin
          quo_q <= acc_nxt[FC_W-1:0];
          mod_q <= rem_nxt;
        end
      end
      ST_MULL: begin
        left_q <= prod_sat;
      end
      ST_MULT: begin
        top_q <= prod_sat;
      end
      ST_DONE: begin
        if (out_free) begin
          out_q.frame_index  <= fidx_q[TGT_W-1:0];
          out_q.cell_left    <= left_q;
          out_q.cell_top     <= top_q;
          out_q.cell_width   <= cw_q;
          out_q.cell_height  <= ch_q;
          out_q.run_mode     <= mode_q;
          out_q.stop_event   <= ev_q;
          out_q.image_loaded <= img_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the sprite frame sequencer: directed rows, then random phases against a predictor
`timescale 1ns / 100ps

module tb;
  import sfs_pkg::*;

  // action codes the block ignores
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

  // one row of the directed part: a register write or an item
  typedef struct {
    bit                  is_write;
    logic [CIDX_W-1:0]   reg_idx;
    logic [CDATA_W-1:0]  reg_val;
    in_item_t            item;
    bit                  typed;
    out_item_t           want;
  } stim_row_t;

  logic               clk;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CDATA_W-1:0] cfg_data;

  // predictor copy of the registers
  logic [FC_W-1:0]  fc_reg;
  logic [PER_W-1:0] period_reg;
  logic             loop_reg;
  logic [FC_W-1:0]  cols_reg;
  logic [FC_W-1:0]  rows_reg;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  // predictor copy of the sequencer state
  logic [MODE_W-1:0] run_state;
  int                frame_pos;
  logic [TIME_W-1:0] last_step_time;
  logic              image_ok;

  out_item_t pending_cells[$];
  int        mismatch_cnt = 0;
  int        send_gap_pct = 0;
  int        stall_pct = 0;
  int        hold_asked = 0;

  sprite_frame_sequencer_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // frame count as the block uses it
  function automatic int frames_in_use();
    if (fc_reg == 0) return 1;
    if (fc_reg > MaxFramesDef) return MaxFramesDef;
    return int'(fc_reg);
  endfunction

  // steps the sequencer state for one item and returns the cell it shows
  function automatic out_item_t advance_sequencer(in_item_t it);
    int                fc, f, cols, rws, sw, sh, cw, ch, left, top;
    logic [TIME_W-1:0] gap;
    logic              stopped;
    out_item_t         r;
    fc = frames_in_use();
    stopped = 1'b0;
    case (it.action)
      ACT_TICK: begin
        gap = it.now_time - last_step_time;
        if (image_ok && (run_state == MODE_PLAY || run_state == MODE_REVERSE) &&
            $signed(gap) > $signed({1'b0, period_reg})) begin
          last_step_time = it.now_time;
          if (run_state == MODE_PLAY) begin
            frame_pos++;
            if (frame_pos >= fc) begin
              if (loop_reg) begin
                frame_pos = 0;
              end else begin
                frame_pos = fc - 1;
                run_state = MODE_STOP;
                stopped = 1'b1;
              end
            end
          end else begin
            frame_pos--;
            if (frame_pos < 0) begin
              if (loop_reg) begin
                frame_pos = fc - 1;
              end else begin
                frame_pos = 0;
                run_state = MODE_STOP;
                stopped = 1'b1;
              end
            end
          end
        end
      end
      ACT_PLAY: run_state = it.direction ? MODE_PLAY : MODE_REVERSE;
      ACT_PAUSE: run_state = MODE_PAUSE;
      ACT_STOP: begin
        run_state = MODE_STOP;
        frame_pos = 0;
      end
      ACT_GOTO: begin
        if (int'(it.target_frame) < fc) begin
          run_state = MODE_PAUSE;
          frame_pos = int'(it.target_frame);
        end
      end
      ACT_RESTART: begin
        run_state = it.direction ? MODE_PLAY : MODE_REVERSE;
        frame_pos = it.direction ? -1 : fc;
        image_ok = it.image_valid;
      end
      default: ;
    endcase
    // clamp the frame and place it in the sheet
    f = frame_pos;
    if (f < 0) f = 0;
    if (f > fc - 1) f = fc - 1;
    cols = (cols_reg == 0) ? 1 : int'(cols_reg);
    rws = (rows_reg == 0) ? 1 : int'(rows_reg);
    sw = (width_reg > MaxSheetDimDef) ? MaxSheetDimDef : int'(width_reg);
    sh = (height_reg > MaxSheetDimDef) ? MaxSheetDimDef : int'(height_reg);
    cw = sw / cols;
    ch = sh / rws;
    left = (f % cols) * cw;
    top = (f / cols) * ch;
    if (left > 4095) left = 4095;
    if (top > 4095) top = 4095;
    r.frame_index = TGT_W'(f);
    r.cell_left = POS_W'(left);
    r.cell_top = POS_W'(top);
    r.cell_width = DIM_W'(cw);
    r.cell_height = DIM_W'(ch);
    r.run_mode = run_state;
    r.stop_event = stopped;
    r.image_loaded = image_ok;
    return r;
  endfunction

  // directed row builders
  function automatic stim_row_t op(logic [ACT_W-1:0] a, logic [TIME_W-1:0] t, logic d,
                                   logic [TGT_W-1:0] g, logic v);
    stim_row_t s;
    s.is_write = 1'b0;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.item = in_item_t'{a, t, d, g, v};
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic stim_row_t wr(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
    stim_row_t s;
    s = op(ACT_TICK, '0, 1'b0, '0, 1'b0);
    s.is_write = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic stim_row_t known(stim_row_t s, out_item_t w);
    s.typed = 1'b1;
    s.want = w;
    return s;
  endfunction

  // frame 0 of a one-cell sheet with no image, as after reset
  function automatic out_item_t reset_cell(logic [MODE_W-1:0] m);
    return out_item_t'{8'd0, 12'd0, 12'd0, 13'd1, 13'd1, m, 1'b0, 1'b0};
  endfunction

  // offers one item, with random gaps, and records its expected cell
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t guess;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < send_gap_pct) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_item <= it;
        break;
      end
    end
    do @(posedge clk); while (in_stall);
    guess = advance_sequencer(it);
    pending_cells.push_back(typed ? want : guess);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
  endtask

  // one register write, mirrored into the predictor
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_COUNT:  fc_reg = FC_W'(val);
      REG_PERIOD:       period_reg = PER_W'(val);
      REG_LOOP_ENABLE:  loop_reg = val[0];
      REG_COLUMNS:      cols_reg = FC_W'(val);
      REG_ROWS:         rows_reg = FC_W'(val);
      REG_SHEET_WIDTH:  width_reg = DIM_W'(val);
      REG_SHEET_HEIGHT: height_reg = DIM_W'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls plus a long hold-off when asked
  initial begin
    int hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // compare each accepted result with the oldest expectation
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_ni && out_valid && !out_stall) begin
        if (pending_cells.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: frame %0d mode %0d", out_item.frame_index,
                     out_item.run_mode);
        end else begin
          want = pending_cells.pop_front();
          if (out_item !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"mismatch: exp frame %0d left %0d top %0d w %0d h %0d mode %0d ",
                        "stop %0b img %0b | got frame %0d left %0d top %0d w %0d h %0d ",
                        "mode %0d stop %0b img %0b"},
                       want.frame_index, want.cell_left, want.cell_top, want.cell_width,
                       want.cell_height, want.run_mode, want.stop_event, want.image_loaded,
                       out_item.frame_index, out_item.cell_left, out_item.cell_top,
                       out_item.cell_width, out_item.cell_height, out_item.run_mode,
                       out_item.stop_event, out_item.image_loaded);
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t         directed_rows[$];
    in_item_t          it;
    int                r, fc;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fc_reg = FC_W'(1);
    period_reg = PERIOD_RST;
    loop_reg = 1'b0;
    cols_reg = FC_W'(1);
    rows_reg = FC_W'(1);
    width_reg = DIM_W'(1);
    height_reg = DIM_W'(1);
    run_state = MODE_PLAY;
    frame_pos = 0;
    last_step_time = '0;
    image_ok = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // after reset: no image, single frame, one-pixel sheet
    directed_rows.push_back(known(op(ACT_TICK, 32'd0, 1'b0, 8'd0, 1'b0),
                                  reset_cell(MODE_PLAY)));
    directed_rows.push_back(known(op(ACT_UNUSED_HI, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1),
                                  reset_cell(MODE_PLAY)));
    directed_rows.push_back(known(op(ACT_PAUSE, 32'd0, 1'b0, 8'd0, 1'b0),
                                  reset_cell(MODE_PAUSE)));
    directed_rows.push_back(known(op(ACT_GOTO, 32'd0, 1'b0, 8'd0, 1'b0),
                                  reset_cell(MODE_PAUSE)));
    directed_rows.push_back(known(op(ACT_STOP, 32'd0, 1'b0, 8'd0, 1'b0),
                                  reset_cell(MODE_STOP)));
    // frame count above the maximum, zero columns and rows, oversize sheet
    directed_rows.push_back(wr(REG_FRAME_COUNT, 32'd511));
    directed_rows.push_back(wr(REG_PERIOD, 32'd0));
    directed_rows.push_back(wr(REG_LOOP_ENABLE, 32'd0));
    directed_rows.push_back(wr(REG_COLUMNS, 32'd0));
    directed_rows.push_back(wr(REG_ROWS, 32'd0));
    directed_rows.push_back(wr(REG_SHEET_WIDTH, 32'd8191));
    directed_rows.push_back(wr(REG_SHEET_HEIGHT, 32'd8191));
    directed_rows.push_back(op(ACT_RESTART, 32'd0, 1'b1, 8'd0, 1'b1));
    directed_rows.push_back(op(ACT_TICK, 32'd1, 1'b0, 8'd0, 1'b0));
    // last frame lands far below the sheet
    directed_rows.push_back(op(ACT_GOTO, 32'd0, 1'b0, 8'd255, 1'b0));
    directed_rows.push_back(op(ACT_PLAY, 32'd0, 1'b0, 8'd0, 1'b0));
    // time going backwards does not advance
    directed_rows.push_back(op(ACT_TICK, 32'h8000_0001, 1'b0, 8'd0, 1'b0));
    directed_rows.push_back(op(ACT_TICK, 32'd3, 1'b0, 8'd0, 1'b0));
    // zero frame count, zero sheet, widest columns, longest period
    directed_rows.push_back(wr(REG_FRAME_COUNT, 32'd0));
    directed_rows.push_back(wr(REG_PERIOD, 32'h7FFF_FFFF));
    directed_rows.push_back(wr(REG_LOOP_ENABLE, 32'd1));
    directed_rows.push_back(wr(REG_COLUMNS, 32'd511));
    directed_rows.push_back(wr(REG_ROWS, 32'd1));
    directed_rows.push_back(wr(REG_SHEET_WIDTH, 32'd0));
    directed_rows.push_back(wr(REG_SHEET_HEIGHT, 32'd0));
    directed_rows.push_back(op(ACT_GOTO, 32'd0, 1'b0, 8'd1, 1'b0));
    directed_rows.push_back(op(ACT_RESTART, 32'd0, 1'b0, 8'd0, 1'b1));
    directed_rows.push_back(op(ACT_TICK, 32'h8000_0002, 1'b0, 8'd0, 1'b0));
    // two frames without looping: run off both ends
    directed_rows.push_back(wr(REG_FRAME_COUNT, 32'd2));
    directed_rows.push_back(wr(REG_PERIOD, 32'd10));
    directed_rows.push_back(wr(REG_LOOP_ENABLE, 32'd0));
    directed_rows.push_back(wr(REG_COLUMNS, 32'd3));
    directed_rows.push_back(wr(REG_ROWS, 32'd2));
    directed_rows.push_back(wr(REG_SHEET_WIDTH, 32'd100));
    directed_rows.push_back(wr(REG_SHEET_HEIGHT, 32'd50));
    directed_rows.push_back(op(ACT_RESTART, 32'd0, 1'b1, 8'd0, 1'b1));
    directed_rows.push_back(op(ACT_TICK, 32'd100, 1'b0, 8'd0, 1'b0));
    directed_rows.push_back(op(ACT_TICK, 32'd200, 1'b0, 8'd0, 1'b0));
    directed_rows.push_back(op(ACT_TICK, 32'd300, 1'b0, 8'd0, 1'b0));
    directed_rows.push_back(op(ACT_RESTART, 32'd0, 1'b0, 8'd0, 1'b1));
    directed_rows.push_back(op(ACT_TICK, 32'd400, 1'b0, 8'd0, 1'b0));
    directed_rows.push_back(op(ACT_TICK, 32'd500, 1'b0, 8'd0, 1'b0));
    directed_rows.push_back(op(ACT_TICK, 32'd600, 1'b0, 8'd0, 1'b0));
    // looping in reverse wraps to the last frame
    directed_rows.push_back(wr(REG_LOOP_ENABLE, 32'd1));
    directed_rows.push_back(op(ACT_RESTART, 32'd0, 1'b0, 8'd0, 1'b1));
    directed_rows.push_back(op(ACT_TICK, 32'd700, 1'b0, 8'd0, 1'b0));
    directed_rows.push_back(op(ACT_TICK, 32'd800, 1'b0, 8'd0, 1'b0));
    directed_rows.push_back(op(ACT_TICK, 32'd900, 1'b0, 8'd0, 1'b0));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        drain();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random phases, each with its own register setting and idling pattern
    for (int p = 0; p < 12; p++) begin
      drain();
      r = $urandom_range(0, 99);
      write_reg(REG_FRAME_COUNT, r < 8 ? 0 : r < 16 ? 256 : r < 22 ? 511 :
                r < 30 ? $urandom_range(1, 511) : $urandom_range(1, 12));
      r = $urandom_range(0, 99);
      write_reg(REG_PERIOD, r < 10 ? 0 : r < 16 ? 32'h7FFF_FFFF : r < 26 ? $urandom :
                $urandom_range(0, 40));
      write_reg(REG_LOOP_ENABLE, $urandom_range(0, 1));
      r = $urandom_range(0, 99);
      write_reg(REG_COLUMNS, r < 8 ? 0 : r < 14 ? 511 : r < 20 ? $urandom_range(0, 511) :
                $urandom_range(1, 5));
      r = $urandom_range(0, 99);
      write_reg(REG_ROWS, r < 8 ? 0 : r < 14 ? 511 : r < 20 ? $urandom_range(0, 511) :
                $urandom_range(1, 5));
      r = $urandom_range(0, 99);
      write_reg(REG_SHEET_WIDTH, r < 8 ? 0 : r < 14 ? 8191 : r < 20 ? 4096 :
                r < 30 ? $urandom_range(0, 8191) : $urandom_range(1, 300));
      r = $urandom_range(0, 99);
      write_reg(REG_SHEET_HEIGHT, r < 8 ? 0 : r < 14 ? 8191 : r < 20 ? 4096 :
                r < 30 ? $urandom_range(0, 8191) : $urandom_range(1, 300));
      send_gap_pct = (p % 4 == 1) ? 63 : (p % 4 == 3) ? 8 : 0;
      stall_pct = (p % 4 == 2) ? 63 : (p % 4 == 3) ? 8 : 0;
      // long hold-off on the result side while items keep coming
      if (p == 2) hold_asked++;
      for (int n = 0; n < 138; n++) begin
        if (p == 6 && n == 69) drain();
        fc = frames_in_use();
        it.now_time = $urandom;
        it.direction = 1'($urandom_range(0, 1));
        it.target_frame = TGT_W'($urandom);
        it.image_valid = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 60) begin
          it.action = ACT_TICK;
          r = $urandom_range(0, 99);
          // mostly right at the period boundary, so frames step or only just do not
          if (r < 60)
            it.now_time = last_step_time + {1'b0, period_reg} + $urandom_range(0, 1);
          else if (r < 80)
            it.now_time = last_step_time + $urandom_range(0, 20);
        end else if (r < 67) begin
          it.action = ACT_PLAY;
        end else if (r < 72) begin
          it.action = ACT_PAUSE;
        end else if (r < 76) begin
          it.action = ACT_STOP;
        end else if (r < 84) begin
          it.action = ACT_GOTO;
          if ($urandom_range(0, 1)) it.target_frame = TGT_W'($urandom_range(0, fc - 1));
        end else if (r < 96) begin
          it.action = ACT_RESTART;
          it.image_valid = ($urandom_range(0, 99) < 85);
        end else begin
          it.action = $urandom_range(0, 1) ? ACT_UNUSED_HI : ACT_UNUSED_LO;
        end
        send_item(it, 1'b0, '0);
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cells.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
